@@ hw/rtl/xbrs_pkg.sv @@
// Shared constants and types for the bounded xoshiro256** random source.
// No dependencies; used by every module of the block.
`default_nettype none

package xbrs_pkg;

    localparam int unsigned WordW      = 64;
    localparam int unsigned BoundW     = 32;
    localparam int unsigned NumWords   = 4;
    localparam int unsigned QueueDepth = 2;

    localparam logic [WordW-1:0] SmGamma = 64'h9e3779b97f4a7c15;
    localparam logic [WordW-1:0] SmMul1  = 64'hbf58476d1ce4e5b9;
    localparam logic [WordW-1:0] SmMul2  = 64'h94d049bb133111eb;

    localparam int unsigned RotOut   = 7;
    localparam int unsigned ShiftT   = 17;
    localparam int unsigned RotState = 45;

    // One pending draw: the raw generator output and the requested bound.
    typedef struct packed {
        logic [WordW-1:0]  raw;
        logic [BoundW-1:0] bound;
    } t_draw;

endpackage

`default_nettype wire

@@ hw/rtl/xbrs_front.sv @@
// Front end: splitmix64 seeding sequencer and the xoshiro256** state update.
// Depends on xbrs_pkg; pushes raw outputs and bounds into xbrs_queue.
`default_nettype none

module xbrs_front
    import xbrs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_write,
    input  wire logic [WordW-1:0]  i_seed_value,
    input  wire logic              i_in_valid,
    input  wire logic [BoundW-1:0] i_draw_bound,
    output logic                   o_in_stall,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_draw                  o_push_item
);

    typedef enum logic [2:0] {
        F_ADD,
        F_MUL1,
        F_XOR2,
        F_MUL2,
        F_XOR3,
        F_READY,
        F_OUT
    } t_fstate;

    t_fstate           r_state;
    logic [WordW-1:0]  r_ctr;
    logic [WordW-1:0]  r_z;
    logic [WordW-1:0]  r_acc;
    logic [1:0]        r_mph;
    logic [1:0]        r_widx;
    logic [WordW-1:0]  r_words [NumWords];
    logic [WordW-1:0]  r_x;
    logic [BoundW-1:0] r_bound;

    logic [WordW-1:0]  n_ctr;
    logic [WordW-1:0]  mul_const;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [WordW-1:0]  acc_sum;
    logic [WordW-1:0]  s1x5;
    logic [WordW-1:0]  t_shift;
    logic [WordW-1:0]  w2a;
    logic [WordW-1:0]  w3a;
    logic              accept;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != F_READY) || i_q_full;

    assign o_push            = (r_state == F_OUT);
    assign o_push_item.raw   = r_x + {r_x[WordW-4:0], 3'b000};
    assign o_push_item.bound = r_bound;

    always_comb begin
        n_ctr     = r_ctr + SmGamma;
        mul_const = (r_state == F_MUL1) ? SmMul1 : SmMul2;
        case (r_mph)
            2'd0: begin
                mul_a = r_z[31:0];
                mul_b = mul_const[31:0];
            end
            2'd1: begin
                mul_a = r_z[63:32];
                mul_b = mul_const[31:0];
            end
            default: begin
                mul_a = r_z[31:0];
                mul_b = mul_const[63:32];
            end
        endcase
        // The 64-bit product modulo 2^64 is built from three 32x32 partial products.
        mul_p   = 64'(mul_a) * 64'(mul_b);
        acc_sum = r_acc + {mul_p[31:0], 32'h0};

        s1x5    = r_words[1] + {r_words[1][WordW-3:0], 2'b00};
        t_shift = {r_words[1][WordW-1-ShiftT:0], {ShiftT{1'b0}}};
        w2a     = r_words[2] ^ r_words[0];
        w3a     = r_words[3] ^ r_words[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_ADD;
            r_ctr   <= '0;
            r_mph   <= '0;
            r_widx  <= '0;
        end else if (i_cfg_write) begin
            r_state <= F_ADD;
            r_ctr   <= i_seed_value;
            r_mph   <= '0;
            r_widx  <= '0;
        end else begin
            unique case (r_state)
                F_ADD: begin
                    r_ctr   <= n_ctr;
                    r_z     <= n_ctr ^ (n_ctr >> 30);
                    r_mph   <= '0;
                    r_state <= F_MUL1;
                end
                F_MUL1, F_MUL2: begin
                    if (r_mph == 2'd0) begin
                        r_acc <= mul_p;
                        r_mph <= 2'd1;
                    end else if (r_mph == 2'd1) begin
                        r_acc <= acc_sum;
                        r_mph <= 2'd2;
                    end else begin
                        r_z     <= acc_sum;
                        r_mph   <= '0;
                        r_state <= (r_state == F_MUL1) ? F_XOR2 : F_XOR3;
                    end
                end
                F_XOR2: begin
                    r_z     <= r_z ^ (r_z >> 27);
                    r_state <= F_MUL2;
                end
                F_XOR3: begin
                    r_words[r_widx] <= r_z ^ (r_z >> 31);
                    r_widx          <= r_widx + 2'd1;
                    r_state         <= (r_widx == 2'd3) ? F_READY : F_ADD;
                end
                F_READY: begin
                    if (accept) begin
                        r_x        <= {s1x5[WordW-1-RotOut:0], s1x5[WordW-1:WordW-RotOut]};
                        r_bound    <= i_draw_bound;
                        r_words[0] <= r_words[0] ^ w3a;
                        r_words[1] <= r_words[1] ^ w2a;
                        r_words[2] <= w2a ^ t_shift;
                        r_words[3] <= {w3a[WordW-1-RotState:0],
                                       w3a[WordW-1:WordW-RotState]};
                        r_state    <= F_OUT;
                    end
                end
                F_OUT: begin
                    r_state <= F_READY;
                end
                default: begin
                    r_state <= F_ADD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/xbrs_queue.sv @@
// Small first-in first-out queue of pending draws between front and back end.
// Depends on xbrs_pkg for the item type.
`default_nettype none

module xbrs_queue
    import xbrs_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_draw i_push_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_draw      o_head
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_draw           r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/xbrs_back.sv @@
// Back end: radix-4 restoring remainder unit and the output register.
// Depends on xbrs_pkg; takes draws from xbrs_queue.
`default_nettype none

module xbrs_back
    import xbrs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire t_draw            i_q_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [WordW-1:0]      o_random_value
);

    localparam int unsigned Steps = WordW / 2;
    localparam int unsigned CntW  = $clog2(Steps);
    localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } t_bstate;

    t_bstate           r_state;
    logic [WordW-1:0]  r_dvd;
    logic [BoundW-1:0] r_rem;
    logic [BoundW-1:0] r_b;
    logic [BoundW+1:0] r_b3;
    logic [CntW-1:0]   r_cnt;
    logic [WordW-1:0]  r_res;
    logic              r_out_valid;
    logic [WordW-1:0]  r_out_value;

    logic [BoundW+1:0] part;
    logic [BoundW+2:0] d1;
    logic [BoundW+2:0] d2;
    logic [BoundW+2:0] d3;
    logic [BoundW-1:0] n_rem;
    logic              out_free;

    assign o_pop          = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_value;
    assign out_free       = !r_out_valid || !i_out_stall;

    always_comb begin
        // Bring in the next two dividend bits and take off the largest multiple that fits.
        part = {r_rem, r_dvd[WordW-1:WordW-2]};
        d1   = {1'b0, part} - {3'b000, r_b};
        d2   = {1'b0, part} - {2'b00, r_b, 1'b0};
        d3   = {1'b0, part} - {1'b0, r_b3};
        if (!d3[BoundW+2]) begin
            n_rem = d3[BoundW-1:0];
        end else if (!d2[BoundW+2]) begin
            n_rem = d2[BoundW-1:0];
        end else if (!d1[BoundW+2]) begin
            n_rem = d1[BoundW-1:0];
        end else begin
            n_rem = part[BoundW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // A finished result moves into the output register once it is free;
            // otherwise an accepted result simply leaves it.
            if (r_state == B_HOLD && out_free) begin
                r_out_value <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_q_head.bound == '0) begin
                            r_res   <= i_q_head.raw;
                            r_state <= B_HOLD;
                        end else begin
                            r_dvd   <= i_q_head.raw;
                            r_rem   <= '0;
                            r_b     <= i_q_head.bound;
                            r_b3    <= {2'b00, i_q_head.bound}
                                       + {1'b0, i_q_head.bound, 1'b0};
                            r_cnt   <= '0;
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[WordW-3:0], 2'b00};
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == LastStep) begin
                        r_res   <= {{(WordW-BoundW){1'b0}}, n_rem};
                        r_state <= B_HOLD;
                    end
                end
                B_HOLD: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/xoshiro_bounded_random_source_core.sv @@
// A zero bound passes the raw output through; a nonzero bound is reduced in the
// radix-4 remainder unit, which retires two dividend bits per cycle. Draw requests
// are accepted while that unit works on an earlier draw, until the queue is full.
// Reset (synchronous, active low) sets the seed to zero and starts a seeding pass over
// all four generator words; a seed write starts the same pass. Input stalls meanwhile.
`default_nettype none

module xoshiro_bounded_random_source_core
    import xbrs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Seed register write channel.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [WordW-1:0]  i_seed_value,
    // Draw requests.
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BoundW-1:0] i_draw_bound,
    // Results.
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [WordW-1:0]       o_random_value
);

    // The seed register is always writable. A write restarts the splitmix64
    // expansion, which rebuilds all four generator words from the new seed.
    logic  cfg_write;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    t_draw q_push_item;
    t_draw q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    // The front end advances the generator as soon as an item is accepted and
    // hands the raw output with its bound to the queue, so that requests keep
    // flowing while the remainder unit is busy with an earlier item.
    xbrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_write  (cfg_write),
        .i_seed_value (i_seed_value),
        .i_in_valid   (i_in_valid),
        .i_draw_bound (i_draw_bound),
        .o_in_stall   (o_in_stall),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_item  (q_push_item)
    );

    xbrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (q_push_item),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    // The back end reduces each raw output modulo its bound, or passes it on
    // untouched for a zero bound, and holds the result in the output register.
    xbrs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value)
    );

endmodule

`default_nettype wire
